// ===== rtl/core/brkg_pkg.sv =====
// package for the block reverse-in-groups-of-k design
// holds the control state, cell opcode and cell data types shared by all files
// no dependencies
package brkg_pkg;

	localparam int unsigned VAL_W = 16;
	localparam int unsigned GS_W  = 7;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_REV,
		ST_FWD
	} brkg_state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_UP,
		OP_DOWN
	} cell_op_t;

	typedef struct packed {
		logic             vld;
		logic [VAL_W-1:0] val;
	} cell_data_t;

endpackage

// ===== rtl/core/block_reverse_k_group.sv =====
// top level of the reverse-in-groups-of-k stream block
// a chain of brkg_cell instances plus the fill/emit sequencer
// depends on brkg_pkg and brkg_cell
//
// Values are taken one per cycle while filling, into a chain of MAX_GROUP
// cells; the newest value always sits in cell 0. When the fill count reaches
// the group size (group_size 0 acts as 1, values above MAX_GROUP act as
// MAX_GROUP), the group leaves newest first from cell 0, one result per cycle
// while out_ready is high, the chain shifting down. When seq_end arrives with
// a partial group, the chain shifts up until the oldest value reaches the top
// cell, then the group leaves oldest first from there. No request is taken
// while a group is being emitted. run_last marks the last result of a group,
// seq_done the last result of the sequence. group_size must be written only
// while the block is idle; the block itself does not enforce this.
module block_reverse_k_group #(
	parameter int unsigned MAX_GROUP = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [brkg_pkg::GS_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [brkg_pkg::VAL_W-1:0]  value,
	input  logic                        seq_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [brkg_pkg::VAL_W-1:0]  out_value,
	output logic                        run_last,
	output logic                        seq_done
);
	import brkg_pkg::*;

	localparam int unsigned CW = $clog2(MAX_GROUP + 1);

	brkg_state_t       state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic              last_q, last_d;
	logic [GS_W-1:0]   gs_q;
	logic [CW-1:0]     k_eff;
	logic [CW-1:0]     count_inc;
	logic              in_acc, out_acc;
	cell_op_t          op;
	cell_data_t        cell_q  [MAX_GROUP];
	cell_data_t        lo_in   [MAX_GROUP];
	cell_data_t        hi_in   [MAX_GROUP];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q <= GS_W'(1);
		end else if (cfg_we) begin
			gs_q <= cfg_wdata;
		end
	end

	// zero acts as one, oversize saturates
	always_comb begin
		if (gs_q == '0) begin
			k_eff = CW'(1);
		end else if (gs_q > GS_W'(MAX_GROUP)) begin
			k_eff = CW'(MAX_GROUP);
		end else begin
			k_eff = gs_q[CW-1:0];
		end
	end

	assign count_inc = count_q + CW'(1);
	assign in_ready  = (state_q == ST_FILL);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	always_comb begin
		case (state_q)
			ST_REV: begin
				out_valid = cell_q[0].vld;
				out_value = cell_q[0].val;
			end
			ST_FWD: begin
				out_valid = cell_q[MAX_GROUP-1].vld;
				out_value = cell_q[MAX_GROUP-1].val;
			end
			default: begin
				out_valid = 1'b0;
				out_value = cell_q[0].val;
			end
		endcase
	end

	assign run_last = (count_q == CW'(1));
	assign seq_done = run_last && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			count_q <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		last_d  = last_q;
		op      = OP_HOLD;
		case (state_q)
			ST_FILL: begin
				if (in_acc) begin
					op      = OP_UP;
					count_d = count_inc;
					last_d  = seq_end;
					if (count_inc >= k_eff) begin
						state_d = ST_REV;
					end else if (seq_end) begin
						state_d = ST_FWD;
					end
				end
			end
			ST_REV: begin
				if (out_acc) begin
					op      = OP_DOWN;
					count_d = count_q - CW'(1);
					if (run_last) begin
						state_d = ST_FILL;
					end
				end
			end
			ST_FWD: begin
				// climb until the oldest value sits in the top cell
				if (!out_valid || out_ready) begin
					op = OP_UP;
				end
				if (out_acc) begin
					count_d = count_q - CW'(1);
					if (run_last) begin
						state_d = ST_FILL;
					end
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
		if (i == 0) begin : g_lo_edge
			assign lo_in[i] = '{vld: (state_q == ST_FILL), val: value};
		end else begin : g_lo_mid
			assign lo_in[i] = cell_q[i-1];
		end
		if (i == MAX_GROUP - 1) begin : g_hi_edge
			assign hi_in[i] = '{vld: 1'b0, val: cell_q[i].val};
		end else begin : g_hi_mid
			assign hi_in[i] = cell_q[i+1];
		end

		brkg_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (op),
			.from_lo (lo_in[i]),
			.from_hi (hi_in[i]),
			.q       (cell_q[i])
		);
	end

	a_valid_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count_q != '0))
		else $error("result shown with empty fill count");

	a_no_out_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> !out_valid)
		else $error("result shown while filling");

	a_group_end_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && run_last) |=> (state_q == ST_FILL) && (count_q == '0))
		else $error("group end did not return to fill");

	// a lowered group size may leave the count at or above it until the next request
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (count_q < CW'(MAX_GROUP)))
		else $error("fill count reached chain depth while filling");

endmodule

// ===== rtl/core/brkg_cell.sv =====
// one storage cell of the bidirectional shift chain
// holds one value and its valid bit, loads from either neighbor
// depends on brkg_pkg
module brkg_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  brkg_pkg::cell_op_t    op,
	input  brkg_pkg::cell_data_t  from_lo,
	input  brkg_pkg::cell_data_t  from_hi,
	output brkg_pkg::cell_data_t  q
);
	import brkg_pkg::*;

	logic             vld_q;
	logic [VAL_W-1:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			case (op)
				OP_UP:   vld_q <= from_lo.vld;
				OP_DOWN: vld_q <= from_hi.vld;
				default: vld_q <= vld_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_UP:   val_q <= from_lo.val;
			OP_DOWN: val_q <= from_hi.val;
			default: val_q <= val_q;
		endcase
	end

	assign q = '{vld: vld_q, val: val_q};

endmodule
